// ===== src/krt_pkg.sv =====
package krt_pkg;

  // op codes carried on in_tuser
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_EXISTS = 3'd3,
    OP_LIST   = 3'd4
  } op_t;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CNT_OUT_W = 4;
  localparam int unsigned IN_DATA_W  = 256;
  localparam int unsigned OUT_DATA_W = 264;

  // one stored record; id sits in the lowest bits
  typedef struct packed {
    logic [WORD_W-1:0] grade_c;
    logic [WORD_W-1:0] grade_b;
    logic [WORD_W-1:0] grade_a;
    logic [WORD_W-1:0] subject_c;
    logic [WORD_W-1:0] subject_b;
    logic [WORD_W-1:0] subject_a;
    logic [WORD_W-1:0] year;
    logic [WORD_W-1:0] id;
  } rec_t;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic shift;      // rotate one place toward cell 0
    logic close_gap;  // cells at or above pos take their neighbor
    logic append;     // cell at index count loads the new record
  } krt_ctrl_t;

endpackage

// ===== src/krt_cell.sv =====
module krt_cell
  import krt_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned POS_W = 4,
  parameter int unsigned CNT_W = 4
) (
  input  logic             clk,
  input  krt_ctrl_t        ctrl,
  input  logic [POS_W-1:0] pos,
  input  logic [CNT_W-1:0] count,
  input  rec_t             new_rec,
  input  rec_t             nbr_rec,
  output rec_t             rec
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  rec_t rec_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec_r <= nbr_rec;
    end else if (ctrl.close_gap && (pos <= MY_POS)) begin
      rec_r <= nbr_rec;
    end else if (ctrl.append && (count == MY_CNT)) begin
      rec_r <= new_rec;
    end
  end

  assign rec = rec_r;

endmodule

// ===== src/krt_chain.sv =====
module krt_chain
  import krt_pkg::*;
#(
  parameter int unsigned CAPACITY = 10,
  parameter int unsigned POS_W    = 4,
  parameter int unsigned CNT_W    = 4
) (
  input  logic             clk,
  input  krt_ctrl_t        ctrl,
  input  logic [POS_W-1:0] pos,
  input  logic [CNT_W-1:0] count,
  input  rec_t             new_rec,
  output rec_t             head_rec
);

  rec_t cell_rec [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    krt_cell #(
      .IDX   (i),
      .POS_W (POS_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pos     (pos),
      .count   (count),
      .new_rec (new_rec),
      .nbr_rec (cell_rec[(i + 1) % CAPACITY]),
      .rec     (cell_rec[i])
    );
  end

  assign head_rec = cell_rec[0];

endmodule

// ===== src/keyed_record_table.sv =====
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser: op; tdata: record to add / key
// out_     out  tvalid/tready      tuser: ok; tdata: record, count, full; tlast
//
// Add and unknown ops: S_DONE registers the result, then the next input is taken.
// Delete, read, exists: a walk over all CAPACITY cells, then S_DONE gives result and next input;
// delete closes the gap in its result cycle.
// List: one result per record during the walk (one not-ok result if empty); next input after the walk.
// The walk stalls while a list result waits; result cycles wait for a free output.
// Reset clears control state and the count; record contents are never cleared.
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int unsigned CAPACITY = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] op
  input  logic [OP_W-1:0]       in_tuser,
  // [31:0] key_id, [63:32] in_year, [95:64] in_subject_a, [127:96] in_subject_b,
  // [159:128] in_subject_c, [191:160] in_grade_a, [223:192] in_grade_b,
  // [255:224] in_grade_c
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] ok
  output logic                  out_tuser,
  // [31:0] out_id, [63:32] out_year, [95:64] out_subject_a,
  // [127:96] out_subject_b, [159:128] out_subject_c, [191:160] out_grade_a,
  // [223:192] out_grade_b, [255:224] out_grade_c, [259:256] used_count,
  // [260] is_full, [263:261] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int unsigned POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [POS_W-1:0] LAST_STEP = POS_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  rec_t             hit_r, hit_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  krt_ctrl_t ctrl;
  rec_t      head_rec;
  rec_t      in_rec;
  rec_t      res_rec;
  logic      accept, out_free, in_range, is_list, advance, emit_list, wrap, full;
  logic [CNT_W-1:0]   step_cnt, done_cnt;
  logic [CNT_W+3:0]   cnt_ext;

  assign in_rec    = rec_t'(in_tdata);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign step_cnt  = CNT_W'(step_r);
  assign in_range  = step_cnt < count_r;
  assign is_list   = (op_r == OP_LIST);
  assign full      = (count_r >= CAP_CNT);
  assign wrap      = (step_r == LAST_STEP);
  assign advance   = (state_r == S_WALK) && (!(is_list && in_range) || out_free);
  assign emit_list = (state_r == S_WALK) && is_list && in_range && out_free;

  assign ctrl.shift     = advance;
  assign ctrl.append    = accept && (in_tuser == OP_ADD) && !full;
  assign ctrl.close_gap = (state_r == S_DONE) && out_free && (op_r == OP_DELETE)
                          && found_r;

  assign done_cnt = ((op_r == OP_DELETE) && found_r) ? count_r - CNT_W'(1) : count_r;

  krt_chain #(
    .CAPACITY (CAPACITY),
    .POS_W    (POS_W),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .pos      (pos_r),
    .count    (count_r),
    .new_rec  (in_rec),
    .head_rec (head_rec)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    res_rec       = '0;
    cnt_ext       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_tuser;
          key_nxt   = in_rec.id;
          step_nxt  = '0;
          found_nxt = ctrl.append;
          if (ctrl.append) begin
            count_nxt = count_r + CNT_W'(1);
          end
          unique case (in_tuser)
            OP_DELETE, OP_READ, OP_EXISTS, OP_LIST: state_nxt = S_WALK;
            default:                                state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (!is_list && in_range && !found_r && (head_rec.id == key_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = step_r;
          hit_nxt   = head_rec;
        end
        if (emit_list) begin
          res_rec.id    = head_rec.id;
          cnt_ext       = {4'b0, count_r};
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_last_nxt  = (step_cnt + CNT_W'(1)) == count_r;
          out_data_nxt  = {3'b0, full, cnt_ext[3:0], res_rec};
        end
        if (advance) begin
          if (wrap) begin
            step_nxt  = '0;
            state_nxt = (is_list && (count_r != '0)) ? S_IDLE : S_DONE;
          end else begin
            step_nxt = step_r + POS_W'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (found_r) begin
            res_rec    = (op_r == OP_READ) ? hit_r : '0;
            res_rec.id = key_r;
          end
          cnt_ext       = {4'b0, done_cnt};
          count_nxt     = done_cnt;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = found_r;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {3'b0, (done_cnt >= CAP_CNT), cnt_ext[3:0], res_rec};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    hit_r      <= hit_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // count never passes capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("record count above capacity");

  // ring is aligned whenever a new transfer can be taken
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (step_r == '0))
    else $error("ring not aligned in idle");

  // append only lands inside the table
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.append |-> (count_r < CAP_CNT))
    else $error("append into full table");

  // gap closing only for a stored record
  a_close_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.close_gap |-> (CNT_W'(pos_r) < count_r))
    else $error("delete position beyond count");

  // no new transfer is taken while any walk is under way
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !in_tready)
    else $error("input ready during walk");

endmodule

// ===== tb/tb.sv =====
module tb;
  import krt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 10;
  localparam int POOL = 12;
  localparam int RANDOM_ITEMS = 134;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTS = 40;

  // one expected result transfer
  typedef struct packed {
    logic       ok;
    rec_t       rec;
    logic [3:0] used;
    logic       full;
    logic       last;
  } table_result_t;

  class table_scoreboard;
    rec_t          rows[$];
    table_result_t due[$];
    int            errors;
    int            refused;

    function new();
      errors = 0;
      refused = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void push(table_result_t r);
      r.used = 4'(rows.size());
      r.full = (rows.size() >= CAP);
      due.push_back(r);
    endfunction

    // apply one accepted operation to the table copy and queue its results
    function void note_input(logic [OP_W-1:0] op, rec_t item);
      table_result_t r;
      int pos;
      pos = -1;
      foreach (rows[i]) if (pos < 0 && rows[i].id == item.id) pos = i;
      if (op == OP_LIST && rows.size() != 0) begin
        foreach (rows[i]) begin
          r = '0;
          r.ok = 1'b1;
          r.rec.id = rows[i].id;
          r.last = (i == rows.size() - 1);
          push(r);
        end
      end else begin
        r = '0;
        r.last = 1'b1;
        case (op)
          OP_ADD: begin
            if (rows.size() < CAP) begin
              rows.push_back(item);
              r.ok = 1'b1;
              r.rec.id = item.id;
            end else begin
              refused++;
            end
          end
          OP_DELETE: begin
            if (pos >= 0) begin
              rows.delete(pos);
              r.ok = 1'b1;
              r.rec.id = item.id;
            end
          end
          OP_READ: begin
            if (pos >= 0) begin
              r.ok = 1'b1;
              r.rec = rows[pos];
            end
          end
          OP_EXISTS: begin
            if (pos >= 0) begin
              r.ok = 1'b1;
              r.rec.id = item.id;
            end
          end
          default: ;
        endcase
        push(r);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(logic ok, logic [OUT_DATA_W-1:0] data, logic last);
      table_result_t e;
      rec_t got;
      got = data[255:0];
      if (due.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      e = due.pop_front();
      cmp("ok", 32'(ok), 32'(e.ok));
      cmp("id", got.id, e.rec.id);
      cmp("year", got.year, e.rec.year);
      cmp("subject_a", got.subject_a, e.rec.subject_a);
      cmp("subject_b", got.subject_b, e.rec.subject_b);
      cmp("subject_c", got.subject_c, e.rec.subject_c);
      cmp("grade_a", got.grade_a, e.rec.grade_a);
      cmp("grade_b", got.grade_b, e.rec.grade_b);
      cmp("grade_c", got.grade_c, e.rec.grade_c);
      cmp("used_count", 32'(data[259:256]), 32'(e.used));
      cmp("is_full", 32'(data[260]), 32'(e.full));
      cmp("pad", 32'(data[263:261]), 32'd0);
      cmp("tlast", 32'(last), 32'(e.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OP_W-1:0]       in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  table_scoreboard sb = new();
  int              hold_requests = 0;
  int              holds_done = 0;
  int              idle_cycles = 0;
  int              results_seen = 0;
  int              op_seen[8];
  bit              src_steady = 1'b0;
  logic [31:0]     id_pool[POOL];

  keyed_record_table #(.CAPACITY(CAP)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rec_t random_record(logic [31:0] key);
    rec_t r;
    r.id = key;
    r.year = $urandom;
    r.subject_a = $urandom;
    r.subject_b = $urandom;
    r.subject_c = $urandom;
    r.grade_a = $urandom;
    r.grade_b = $urandom;
    r.grade_c = $urandom;
    return r;
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_item(input logic [OP_W-1:0] op, input rec_t item, input bit no_gap);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gap || src_steady || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 30);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= item;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, item);
    op_seen[op]++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int idx, input bit no_gap);
    int roll;
    bit grow;
    logic [OP_W-1:0] op;
    logic [31:0] key;
    // alternate phases that fill and drain the table
    grow = ((idx / 40) % 2) == 0;
    roll = $urandom_range(0, 99);
    if (roll < (grow ? 40 : 12)) op = OP_ADD;
    else if (roll < (grow ? 52 : 50)) op = OP_DELETE;
    else if (roll < 70) op = OP_READ;
    else if (roll < 84) op = OP_EXISTS;
    else if (roll < 95) op = OP_LIST;
    else op = 3'($urandom_range(5, 7));
    key = ($urandom_range(0, 4) == 0) ? $urandom : id_pool[$urandom_range(0, POOL - 1)];
    send_item(op, random_record(key), no_gap);
  endtask

  task automatic run_directed();
    int k;
    // empty table
    send_item(OP_LIST, random_record(32'h0), 1'b0);
    send_item(OP_READ, random_record(32'h0), 1'b0);
    send_item(OP_DELETE, random_record(32'hFFFF_FFFF), 1'b0);
    send_item(OP_EXISTS, random_record(32'h5), 1'b0);
    for (k = 5; k < 8; k++) send_item(3'(k), random_record($urandom), 1'b0);
    // all-zero and all-ones records, then a duplicate id
    send_item(OP_ADD, '0, 1'b0);
    send_item(OP_ADD, '1, 1'b0);
    send_item(OP_ADD, random_record(32'h0), 1'b0);
    for (k = 0; k < CAP - 3; k++) send_item(OP_ADD, random_record(32'h1000_0000 + k), 1'b0);
    send_item(OP_ADD, random_record(32'hABCD_0001), 1'b0);
    send_item(OP_LIST, random_record(32'h0), 1'b0);
    send_item(OP_READ, random_record(32'h0), 1'b0);
    send_item(OP_READ, random_record(32'hFFFF_FFFF), 1'b0);
    send_item(OP_DELETE, random_record(32'h1000_0000 + CAP - 4), 1'b0);
    send_item(OP_DELETE, random_record(32'h0), 1'b0);
    send_item(OP_READ, random_record(32'h0), 1'b0);
    send_item(OP_DELETE, random_record(32'h1000_0002), 1'b0);
    send_item(OP_EXISTS, random_record(32'h1000_0002), 1'b0);
    send_item(OP_LIST, random_record(32'h0), 1'b0);
  endtask

  // result side: check, then pick next ready
  initial begin
    int stall_left;
    int tick;
    bit steady;
    stall_left = 0;
    tick = 0;
    steady = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) begin
        sb.check_result(out_tuser, out_tdata, out_tlast);
        results_seen++;
      end
      tick++;
      if (tick % 128 == 0) steady = ($urandom_range(0, 2) == 0);
      if (holds_done != hold_requests) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= '0;
    in_tdata <= '0;
    foreach (op_seen[j]) op_seen[j] = 0;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < POOL; i++) id_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold while the sender keeps pushing
      if (i == 0) hold_requests++;
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i % 20 == 0) src_steady = ($urandom_range(0, 2) == 0);
      send_random(i, i < 30);
    end
    wait_drained();
    repeat (CAP + 8) @(posedge clk);

    $display("Run covered %0d input transfers: add %0d, delete %0d, read %0d, exists %0d,",
             op_seen.sum(), op_seen[OP_ADD], op_seen[OP_DELETE], op_seen[OP_READ],
             op_seen[OP_EXISTS]);
    $display("  list %0d, undefined ops %0d; %0d results checked, %0d adds refused as full",
             op_seen[OP_LIST], op_seen[5] + op_seen[6] + op_seen[7], results_seen, sb.refused);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/krt_pkg.sv
src/krt_cell.sv
src/krt_chain.sv
src/keyed_record_table.sv
tb/tb.sv
